### design/cpsd_pkg.sv
// package: constants, codes and control types of the closest point search
package cpsd_pkg;
  localparam int MAX_ENTRIES = 1024;
  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int POS_W = 30;
  localparam int GRID_W = 11;
  localparam int DIST_W = 24;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_CNT_W = $clog2(POS_W);
  localparam int DIFF_W = 12;
  localparam int SUM_W = 2 * DIFF_W + 2;
  localparam logic [DIST_W-1:0] DIST_LIMIT = 24'd10000000;

  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_LOAD  = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAINED_ONLY = 2'd2;

  typedef struct packed {
    logic clr;
    logic load;
    logic q_start;
    logic div_start;
    logic div_b;
    logic div_entry;
    logic cap_a;
    logic cap_q;
    logic cap_e;
    logic rd_en;
    logic inc;
    logic sq_en;
    logic cmp_en;
    logic out_en;
  } cpsd_cmd_t;

  typedef struct packed {
    logic div_done;
    logic scan_end;
    logic skip;
    logic out_free;
  } cpsd_stat_t;
endpackage

### design/cpsd_if.sv
// interfaces: input item channel and result channel
interface cpsd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [29:0] position;
  logic        chained;
  modport source (output valid, func, position, chained, input ready);
  modport sink (input valid, func, position, chained, output ready);
endinterface

interface cpsd_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [9:0]  best_index;
  logic [23:0] best_distance;
  modport source (output valid, found, best_index, best_distance, input ready);
  modport sink (input valid, found, best_index, best_distance, output ready);
endinterface

### design/cpsd_ram.sv
// generic single write, single read ram with registered read data
module cpsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule

### design/cpsd_div.sv
// radix-2 restoring divider, one quotient bit per cycle
module cpsd_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [cpsd_pkg::POS_W-1:0]   dividend_i,
  input  logic [cpsd_pkg::GRID_W-1:0]  divisor_i,
  output logic                         done_o,
  output logic [cpsd_pkg::POS_W-1:0]   quot_o,
  output logic [cpsd_pkg::GRID_W-1:0]  rem_o
);
  import cpsd_pkg::*;

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [GRID_W-1:0]    d_q;
  logic [POS_W-1:0]     quot_q;
  logic [GRID_W-1:0]    rem_q;
  logic [GRID_W:0]      trial;
  logic                 fit;

  assign trial = {rem_q, quot_q[POS_W-1]};
  assign fit   = trial >= {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(POS_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      d_q    <= (divisor_i == '0) ? GRID_W'(1) : divisor_i;
      quot_q <= dividend_i;
      rem_q  <= '0;
    end else if (busy_q) begin
      quot_q <= {quot_q[POS_W-2:0], fit};
      rem_q  <= fit ? GRID_W'(trial - {1'b0, d_q}) : trial[GRID_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;
endmodule

### design/cpsd_dp.sv
// datapath: table, config registers, coordinate split, distance and best tracking
module cpsd_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cpsd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [cpsd_pkg::GRID_W-1:0]    cfg_data_i,
  input  logic [cpsd_pkg::POS_W-1:0]     pos_i,
  input  logic                           chained_i,
  input  cpsd_pkg::cpsd_cmd_t            cmd_i,
  output cpsd_pkg::cpsd_stat_t           stat_o,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic                           found_o,
  output logic [cpsd_pkg::IDX_W-1:0]     best_index_o,
  output logic [cpsd_pkg::DIST_W-1:0]    best_distance_o
);
  import cpsd_pkg::*;

  logic [GRID_W-1:0] gx_q, gy_q;
  logic              chon_q;
  logic [CNT_W-1:0]  count_q, idx_q;
  logic [POS_W-1:0]  qpos_q;
  logic [GRID_W-1:0] x_q, qx_q, qy_q, ey_q;
  logic [POS_W-1:0]  qz_q, ez_q;
  logic [POS_W:0]    rdata;
  logic              div_done;
  logic [POS_W-1:0]  quot, dividend;
  logic [GRID_W-1:0] rem, divisor;
  logic [2*DIFF_W-1:0] sx_q, sy_q, sz_q;
  logic              big_q;
  logic [GRID_W-1:0] dx, dy;
  logic [POS_W-1:0]  dz;
  logic [SUM_W-1:0]  sum;
  logic              better;
  logic [DIST_W-1:0] best_q;
  logic [IDX_W-1:0]  besti_q;
  logic              hit_q, ov_q;
  logic              wr_en;

  assign wr_en = cmd_i.load && (count_q < CNT_W'(MAX_ENTRIES));

  cpsd_ram #(.WIDTH(POS_W + 1), .DEPTH(MAX_ENTRIES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i ({chained_i, pos_i}),
    .re_i    (cmd_i.rd_en),
    .raddr_i (idx_q[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  assign dividend = cmd_i.div_b ? quot : (cmd_i.div_entry ? rdata[POS_W-1:0] : qpos_q);
  assign divisor  = cmd_i.div_b ? gy_q : gx_q;

  cpsd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  assign dx  = (qx_q > x_q) ? qx_q - x_q : x_q - qx_q;
  assign dy  = (qy_q > ey_q) ? qy_q - ey_q : ey_q - qy_q;
  assign dz  = (qz_q > ez_q) ? qz_q - ez_q : ez_q - qz_q;
  assign sum = SUM_W'(sx_q) + SUM_W'(sy_q) + SUM_W'(sz_q);
  assign better = !big_q && (sum < SUM_W'(best_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gx_q    <= GRID_W'(1024);
      gy_q    <= GRID_W'(1024);
      chon_q  <= 1'b0;
      count_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_GRID_X:       gx_q   <= cfg_data_i;
          CFG_GRID_Y:       gy_q   <= cfg_data_i;
          CFG_CHAINED_ONLY: chon_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cmd_i.clr) begin
        count_q <= '0;
      end else if (wr_en) begin
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.out_en) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.q_start) begin
      qpos_q  <= pos_i;
      idx_q   <= '0;
      best_q  <= DIST_LIMIT;
      besti_q <= '0;
      hit_q   <= 1'b0;
    end
    if (cmd_i.cap_a) x_q <= rem;
    if (cmd_i.cap_q) begin
      qx_q <= x_q;
      qy_q <= rem;
      qz_q <= quot;
    end
    if (cmd_i.cap_e) begin
      ey_q <= rem;
      ez_q <= quot;
    end
    if (cmd_i.sq_en) begin
      sx_q  <= (2*DIFF_W)'(dx) * (2*DIFF_W)'(dx);
      sy_q  <= (2*DIFF_W)'(dy) * (2*DIFF_W)'(dy);
      sz_q  <= (2*DIFF_W)'(dz[DIFF_W-1:0]) * (2*DIFF_W)'(dz[DIFF_W-1:0]);
      big_q <= dz >= POS_W'(1 << DIFF_W);
    end
    if (cmd_i.cmp_en && better) begin
      best_q  <= sum[DIST_W-1:0];
      besti_q <= idx_q[IDX_W-1:0];
      hit_q   <= 1'b1;
    end
    if (cmd_i.inc || cmd_i.cmp_en) idx_q <= idx_q + 1'b1;
    if (cmd_i.out_en) begin
      found_o         <= hit_q;
      best_index_o    <= hit_q ? besti_q : '0;
      best_distance_o <= hit_q ? best_q : '0;
    end
  end

  assign out_valid_o     = ov_q;
  assign stat_o.div_done = div_done;
  assign stat_o.scan_end = idx_q >= count_q;
  assign stat_o.skip     = chon_q && !rdata[POS_W];
  assign stat_o.out_free = !ov_q || out_ready_i;
endmodule

### design/cpsd_ctrl.sv
// controller: sequences loads, clears and the query scan
module cpsd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [1:0]           func_i,
  output logic                 in_ready_o,
  input  cpsd_pkg::cpsd_stat_t stat_i,
  output cpsd_pkg::cpsd_cmd_t  cmd_o
);
  import cpsd_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_QS   = 11'b00000000010,
    S_QA   = 11'b00000000100,
    S_QB   = 11'b00000001000,
    S_RD   = 11'b00000010000,
    S_RDW  = 11'b00000100000,
    S_EA   = 11'b00001000000,
    S_EB   = 11'b00010000000,
    S_SQ   = 11'b00100000000,
    S_CMP  = 11'b01000000000,
    S_OUT  = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (func_i)
            FUNC_CLEAR: cmd_o.clr = 1'b1;
            FUNC_LOAD:  cmd_o.load = 1'b1;
            FUNC_QUERY: begin
              cmd_o.q_start = 1'b1;
              state_d = S_QS;
            end
            default: ;
          endcase
        end
      end
      S_QS: begin
        cmd_o.div_start = 1'b1;
        state_d = S_QA;
      end
      S_QA: begin
        if (stat_i.div_done) begin
          cmd_o.cap_a = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_b = 1'b1;
          state_d = S_QB;
        end
      end
      S_QB: begin
        if (stat_i.div_done) begin
          cmd_o.cap_q = 1'b1;
          state_d = S_RD;
        end
      end
      S_RD: begin
        if (stat_i.scan_end) begin
          state_d = S_OUT;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d = S_RDW;
        end
      end
      S_RDW: begin
        if (stat_i.skip) begin
          cmd_o.inc = 1'b1;
          state_d = S_RD;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_entry = 1'b1;
          state_d = S_EA;
        end
      end
      S_EA: begin
        if (stat_i.div_done) begin
          cmd_o.cap_a = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_b = 1'b1;
          state_d = S_EB;
        end
      end
      S_EB: begin
        if (stat_i.div_done) begin
          cmd_o.cap_e = 1'b1;
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        cmd_o.sq_en = 1'b1;
        state_d = S_CMP;
      end
      S_CMP: begin
        cmd_o.cmp_en = 1'b1;
        state_d = S_RD;
      end
      S_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_en = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule

### design/closest_point_search_3d.sv
// top level: closest point search over a table of 3d grid points
//
// input channel carries func, position and chained. a clear transaction
// empties the table and a load appends one point; neither gives a
// result. a load into a full table is dropped.
// a query splits the query position and then each stored entry into x, y
// and z with a shared one-bit-per-cycle divider (two divisions per
// point); entries skipped under chained_only get no division.
// one query is worked at a time; ready is high only between transactions.
// the result (found, best_index, best_distance) sits in an output register
// until taken; a stalled receiver holds the next query at its final step
// while no clears or loads are taken. config port writes grid_x, grid_y
// and chained_only; the user does so only while the block idles, which the
// block does not enforce. reset: empty table, 1024 by 1024 grid, no result.
module closest_point_search_3d (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cpsd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [cpsd_pkg::GRID_W-1:0]    cfg_data_i,
  cpsd_in_if.sink                        in_if,
  cpsd_out_if.source                     out_if
);
  import cpsd_pkg::*;

  cpsd_cmd_t  cmd;
  cpsd_stat_t stat;

  cpsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .func_i     (in_if.func),
    .in_ready_o (in_if.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cpsd_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .pos_i           (in_if.position),
    .chained_i       (in_if.chained),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_ready_i     (out_if.ready),
    .out_valid_o     (out_if.valid),
    .found_o         (out_if.found),
    .best_index_o    (out_if.best_index),
    .best_distance_o (out_if.best_distance)
  );
endmodule

### verif/closest_point_search_3d_tb.sv
// testbench: self-checking closest point search with random traffic and stalls
module closest_point_search_3d_tb;
  import cpsd_pkg::*;

  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int LONG_HOLD = 3000;
  localparam int SETTLE = 40;

  typedef struct {
    logic [1:0]  func;
    logic [29:0] position;
    logic        chained;
  } grid_item_t;

  typedef struct {
    logic        found;
    logic [9:0]  best_index;
    logic [23:0] best_distance;
  } nearest_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [GRID_W-1:0] cfg_data;

  cpsd_in_if in_ch ();
  cpsd_out_if out_ch ();

  closest_point_search_3d i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_if     (in_ch),
    .out_if    (out_ch)
  );

  grid_item_t item_q[$];
  nearest_t nearest_q[$];

  // predictor state
  logic [29:0] tbl_pos[MAX_ENTRIES];
  logic        tbl_chained[MAX_ENTRIES];
  int          tbl_count;
  logic [GRID_W-1:0] grid_x;
  logic [GRID_W-1:0] grid_y;
  logic        chained_only;

  // generator shadow of the table
  logic [29:0] gen_pos[$];

  int errors;
  int sent_cnt;
  int acc_cnt;
  int cycles;
  int in_gap;
  bit quiet;
  bit long_req;

  task automatic report(input string what, input longint got, input longint want);
    $display("error: %s got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic longint unsigned sq_delta(longint unsigned a, longint unsigned b);
    longint unsigned d;
    d = (a > b) ? a - b : b - a;
    return d * d;
  endfunction

  function automatic longint unsigned grid_dist(logic [29:0] p1, logic [29:0] p2);
    longint unsigned gx, gy, t1, t2;
    gx = (grid_x == 0) ? 1 : grid_x;
    gy = (grid_y == 0) ? 1 : grid_y;
    t1 = p1 / gx;
    t2 = p2 / gx;
    return sq_delta(p1 % gx, p2 % gx) + sq_delta(t1 % gy, t2 % gy)
         + sq_delta(t1 / gy, t2 / gy);
  endfunction

  function automatic nearest_t nearest_entry(logic [29:0] qpos);
    nearest_t r;
    longint unsigned best, d;
    best = DIST_LIMIT;
    r.found = 0;
    r.best_index = '0;
    r.best_distance = '0;
    for (int i = 0; i < tbl_count; i++) begin
      if (chained_only && !tbl_chained[i]) continue;
      d = grid_dist(qpos, tbl_pos[i]);
      if (d < best) begin
        best = d;
        r.found = 1;
        r.best_index = i[9:0];
        r.best_distance = d[23:0];
      end
    end
    return r;
  endfunction

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  // sender
  always @(negedge clk_i) begin
    grid_item_t it;
    if (rst_ni) begin
      if (in_ch.valid && acc_cnt != sent_cnt) begin
      end else if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (item_q.size() > 0) begin
        it = item_q.pop_front();
        in_ch.func <= it.func;
        in_ch.position <= it.position;
        in_ch.chained <= it.chained;
        in_ch.valid <= 1'b1;
        sent_cnt++;
        if (!quiet && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 13);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // accepted input transaction feeds the predictor
  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      acc_cnt++;
      case (in_ch.func)
        FUNC_CLEAR: tbl_count = 0;
        FUNC_LOAD: begin
          if (tbl_count < MAX_ENTRIES) begin
            tbl_pos[tbl_count] = in_ch.position;
            tbl_chained[tbl_count] = in_ch.chained;
            tbl_count++;
          end
        end
        FUNC_QUERY: nearest_q.push_back(nearest_entry(in_ch.position));
        default: ;
      endcase
    end
  end

  // receiver
  always @(negedge clk_i) begin
    int hold_left;
    int gap_left;
    bit long_done;
    if (rst_ni) begin
      if (long_req && !long_done) begin
        long_done = 1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(0, 12);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    nearest_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (nearest_q.size() == 0) begin
        report("unexpected result, found", out_ch.found, 0);
      end else begin
        e = nearest_q.pop_front();
        if (out_ch.found !== e.found) report("found", out_ch.found, e.found);
        if (out_ch.best_index !== e.best_index)
          report("best_index", out_ch.best_index, e.best_index);
        if (out_ch.best_distance !== e.best_distance)
          report("best_distance", out_ch.best_distance, e.best_distance);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("closest_point_search_3d: mismatch");
      $finish;
    end
  end

  task automatic push_item(input logic [1:0] f, input logic [29:0] p, input logic c);
    grid_item_t it;
    it.func = f;
    it.position = p;
    it.chained = c;
    item_q.push_back(it);
    if (f == FUNC_CLEAR) gen_pos.delete();
    if (f == FUNC_LOAD && gen_pos.size() < MAX_ENTRIES) gen_pos.push_back(p);
  endtask

  task automatic drain();
    wait (item_q.size() == 0 && acc_cnt == sent_cnt && nearest_q.size() == 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [GRID_W-1:0] val);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_GRID_X: grid_x = val;
      CFG_GRID_Y: grid_y = val;
      CFG_CHAINED_ONLY: chained_only = val[0];
      default: ;
    endcase
  endtask

  task automatic set_grid(input int gx, input int gy, input bit co);
    drain();
    cfg_write(CFG_GRID_X, gx[GRID_W-1:0]);
    cfg_write(CFG_GRID_Y, gy[GRID_W-1:0]);
    cfg_write(CFG_CHAINED_ONLY, {{(GRID_W-1){1'b0}}, co});
  endtask

  // random traffic, loads clustered around a center so queries hit
  task automatic random_traffic(input int n, input int spread);
    logic [29:0] center, p;
    int r;
    center = 30'($urandom());
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 6 || (gen_pos.size() > 14 && r < 30)) begin
        push_item(FUNC_CLEAR, 30'($urandom()), 1'($urandom_range(0, 1)));
      end else if (r < 8) begin
        push_item(FUNC_NONE, 30'($urandom()), 1'($urandom_range(0, 1)));
      end else if (r < 55) begin
        if ($urandom_range(0, 3) != 0)
          p = center + 30'($urandom_range(0, 2 * spread)) - 30'(spread);
        else
          p = 30'($urandom());
        push_item(FUNC_LOAD, p, 1'($urandom_range(0, 1)));
      end else begin
        if (gen_pos.size() > 0 && $urandom_range(0, 3) != 0)
          p = gen_pos[$urandom_range(0, gen_pos.size() - 1)]
              + 30'($urandom_range(0, spread / 2)) - 30'(spread / 4);
        else
          p = 30'($urandom());
        push_item(FUNC_QUERY, p, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_CLEAR;
    in_ch.position = '0;
    in_ch.chained = 1'b0;
    out_ch.ready = 1'b0;
    tbl_count = 0;
    grid_x = 11'd1024;
    grid_y = 11'd1024;
    chained_only = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty table, extremes, ties, unknown func
    push_item(FUNC_QUERY, 30'h0, 1'b0);
    push_item(FUNC_LOAD, 30'h0, 1'b0);
    push_item(FUNC_LOAD, 30'h3fffffff, 1'b1);
    push_item(FUNC_QUERY, 30'h0, 1'b0);
    push_item(FUNC_QUERY, 30'h3fffffff, 1'b1);
    push_item(FUNC_LOAD, 30'h0, 1'b1);
    push_item(FUNC_QUERY, 30'h1, 1'b0);
    push_item(FUNC_NONE, 30'h2aaaaaaa, 1'b1);
    push_item(FUNC_QUERY, 30'h15555555, 1'b0);
    push_item(FUNC_CLEAR, 30'h3fffffff, 1'b1);
    push_item(FUNC_QUERY, 30'h0, 1'b0);
    push_item(FUNC_LOAD, 30'h12345678, 1'b0);
    push_item(FUNC_QUERY, 30'h12345679, 1'b1);
    drain();
    set_grid(1, 1, 0);
    push_item(FUNC_QUERY, 30'h12345678 + 30'd3162, 1'b0);
    push_item(FUNC_QUERY, 30'h12345678 + 30'd3163, 1'b0);
    push_item(FUNC_QUERY, 30'h0, 1'b0);
    set_grid(1024, 1024, 1);
    push_item(FUNC_QUERY, 30'h12345678, 1'b0);
    push_item(FUNC_LOAD, 30'h12345000, 1'b1);
    push_item(FUNC_QUERY, 30'h12345678, 1'b0);

    set_grid(1024, 1024, 0);
    random_traffic(110, 3000);
    set_grid(1, 1, 0);
    random_traffic(60, 4000);
    set_grid(0, 0, 1);
    random_traffic(60, 4000);
    set_grid(2047, 2047, 1);
    random_traffic(60, 20000);

    // long receiver hold while the sender keeps offering
    set_grid(64, 64, 0);
    long_req = 1;
    random_traffic(80, 400);
    drain();

    // larger table, few chained entries keep chained-only queries short
    set_grid(3, 7, 1);
    push_item(FUNC_CLEAR, 30'h0, 1'b0);
    for (int i = 0; i < 60; i++)
      push_item(FUNC_LOAD, 30'($urandom_range(0, 4000)), (i % 9) == 5);
    for (int i = 0; i < 3; i++) push_item(FUNC_QUERY, 30'($urandom_range(0, 4000)), 1'b0);
    set_grid(1024, 1024, 0);
    push_item(FUNC_QUERY, 30'($urandom()), 1'b0);

    // last part without idling
    set_grid(37, 5, 1);
    quiet = 1;
    push_item(FUNC_CLEAR, 30'h0, 1'b0);
    random_traffic(120, 300);
    drain();
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("closest_point_search_3d: match");
    end else begin
      $display("closest_point_search_3d: mismatch");
    end
    $finish;
  end
endmodule
